[design/aasf_pkg.sv]
// Package for the ALU, barrel shifter and flags block: operation and condition codes,
// flag bit positions, item structures and the condition check function.
// Depends on nothing; used by aasf_alu and arm_alu_shifter_flags_core.
package aasf_pkg;

    typedef enum logic [3:0] {
        OP_ADD     = 4'd0,
        OP_SUB     = 4'd1,
        OP_LSL     = 4'd2,
        OP_LSR     = 4'd3,
        OP_ASR     = 4'd4,
        OP_ROR     = 4'd5,
        OP_RRX     = 4'd6,
        OP_LOGIC   = 4'd7,
        OP_MUL     = 4'd8,
        OP_COND    = 4'd9,
        OP_WRFLAGS = 4'd10
    } op_t;

    localparam logic [3:0] COND_EQ = 4'd0;
    localparam logic [3:0] COND_NE = 4'd1;
    localparam logic [3:0] COND_CS = 4'd2;
    localparam logic [3:0] COND_CC = 4'd3;
    localparam logic [3:0] COND_MI = 4'd4;
    localparam logic [3:0] COND_PL = 4'd5;
    localparam logic [3:0] COND_VS = 4'd6;
    localparam logic [3:0] COND_VC = 4'd7;
    localparam logic [3:0] COND_HI = 4'd8;
    localparam logic [3:0] COND_LS = 4'd9;
    localparam logic [3:0] COND_GE = 4'd10;
    localparam logic [3:0] COND_LT = 4'd11;
    localparam logic [3:0] COND_GT = 4'd12;
    localparam logic [3:0] COND_LE = 4'd13;
    localparam logic [3:0] COND_AL = 4'd14;
    localparam logic [3:0] COND_NV = 4'd15;

    // NZCV positions within the 4-bit flag word
    localparam int FL_N = 3;
    localparam int FL_Z = 2;
    localparam int FL_C = 1;
    localparam int FL_V = 0;

    localparam logic [2:0] MAX_MUL_CYCLES = 3'd4;

    typedef struct packed {
        logic [3:0]  op;
        logic [31:0] operand_a;
        logic [31:0] operand_b;
        logic [31:0] operand_c;
        logic        carry_in;
        logic [7:0]  shift_amount;
        logic        set_flags;
        logic [3:0]  condition;
    } in_item_t;

    typedef struct packed {
        logic [31:0] result;
        logic        shift_carry_out;
        logic [3:0]  flags_out;
        logic        condition_passed;
        logic [2:0]  mul_cycles;
    } out_item_t;

    function automatic logic cond_holds(input logic [3:0] code, input logic [3:0] f);
        logic n;
        logic z;
        logic c;
        logic v;
        logic ok;
        n = f[FL_N];
        z = f[FL_Z];
        c = f[FL_C];
        v = f[FL_V];
        case (code)
            COND_EQ: ok = z;
            COND_NE: ok = !z;
            COND_CS: ok = c;
            COND_CC: ok = !c;
            COND_MI: ok = n;
            COND_PL: ok = !n;
            COND_VS: ok = v;
            COND_VC: ok = !v;
            COND_HI: ok = c && !z;
            COND_LS: ok = !c || z;
            COND_GE: ok = (n == v);
            COND_LT: ok = (n != v);
            COND_GT: ok = !z && (n == v);
            COND_LE: ok = z || (n != v);
            COND_AL: ok = 1'b1;
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

[design/aasf_in_if.sv]
// Request channel interface: valid/ready handshake plus the operation fields.
// Depends on nothing.
interface aasf_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  op;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    logic [31:0] operand_c;
    logic        carry_in;
    logic [7:0]  shift_amount;
    logic        set_flags;
    logic [3:0]  condition;

    modport source (
        output valid, op, operand_a, operand_b, operand_c, carry_in,
               shift_amount, set_flags, condition,
        input  ready
    );
    modport sink (
        input  valid, op, operand_a, operand_b, operand_c, carry_in,
               shift_amount, set_flags, condition,
        output ready
    );
endinterface

[design/aasf_out_if.sv]
// Result channel interface: valid/ready handshake plus the result fields.
// Depends on nothing.
interface aasf_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] result;
    logic        shift_carry_out;
    logic [3:0]  flags_out;
    logic        condition_passed;
    logic [2:0]  mul_cycles;

    modport source (
        output valid, result, shift_carry_out, flags_out, condition_passed, mul_cycles,
        input  ready
    );
    modport sink (
        input  valid, result, shift_carry_out, flags_out, condition_passed, mul_cycles,
        output ready
    );
endinterface

[design/aasf_alu.sv]
// Single-pass datapath: adder, barrel shifter, multiply-accumulate and flag logic.
// Takes the current flags and shifter carry, returns the result and the next state.
// Depends on aasf_pkg.
module aasf_alu (
    input  aasf_pkg::in_item_t  item,
    input  logic [3:0]          flags,
    input  logic                shift_carry,
    output aasf_pkg::out_item_t res,
    output logic [3:0]          flags_next,
    output logic                shift_carry_next
);

    logic [31:0] a;
    logic [31:0] add_b;
    logic [32:0] sum;
    logic [31:0] mac;
    logic [32:0] lsl_wide;
    logic [32:0] lsr_wide;
    logic [32:0] asr_wide;
    logic [31:0] ror_wide;
    logic [4:0]  sh_lo;
    logic        sh_zero;
    logic        sh_small;
    logic        sh_32;
    logic        cflag;
    logic        ones8;
    logic        ones16;
    logic        ones24;
    logic [31:0] r;
    logic [2:0]  cycles;

    assign a        = item.operand_a;
    assign cflag    = flags[aasf_pkg::FL_C];
    assign sh_lo    = item.shift_amount[4:0];
    assign sh_zero  = (item.shift_amount == 8'd0);
    assign sh_small = (item.shift_amount[7:5] == 3'd0);
    assign sh_32    = (item.shift_amount == 8'd32);

    assign add_b = (item.op == aasf_pkg::OP_SUB) ? ~item.operand_b : item.operand_b;
    assign sum   = {1'b0, a} + {1'b0, add_b} + {32'd0, item.carry_in};
    assign mac   = item.operand_c + (a * item.operand_b);

    // carry comes out of the bit just past the shifted word
    assign lsl_wide = {1'b0, a} << sh_lo;
    assign lsr_wide = {a, 1'b0} >> sh_lo;
    assign asr_wide = 33'($signed({a, 1'b0}) >>> sh_lo);
    assign ror_wide = 32'({a, a} >> sh_lo);

    // each top field of the multiplier that is neither all zero nor all one adds to mul_cycles
    assign ones8  = (item.operand_b[31:8] != 24'd0) && (item.operand_b[31:8] != 24'hffffff);
    assign ones16 = (item.operand_b[31:16] != 16'd0) && (item.operand_b[31:16] != 16'hffff);
    assign ones24 = (item.operand_b[31:24] != 8'd0) && (item.operand_b[31:24] != 8'hff);

    always_comb
    begin
        r                = 32'd0;
        cycles           = 3'd0;
        flags_next       = flags;
        shift_carry_next = shift_carry;
        case (item.op)
            aasf_pkg::OP_ADD, aasf_pkg::OP_SUB:
            begin
                r = sum[31:0];
                if (item.set_flags)
                begin
                    flags_next[aasf_pkg::FL_N] = sum[31];
                    flags_next[aasf_pkg::FL_Z] = (sum[31:0] == 32'd0);
                    flags_next[aasf_pkg::FL_C] = sum[32];
                    flags_next[aasf_pkg::FL_V] = ~(a[31] ^ add_b[31]) & (a[31] ^ sum[31]);
                end
            end
            aasf_pkg::OP_LSL:
            begin
                if (sh_zero)
                begin
                    r                = a;
                    shift_carry_next = cflag;
                end
                else if (sh_small)
                begin
                    r                = lsl_wide[31:0];
                    shift_carry_next = lsl_wide[32];
                end
                else
                begin
                    shift_carry_next = sh_32 ? a[0] : 1'b0;
                end
            end
            aasf_pkg::OP_LSR:
            begin
                if (sh_zero)
                begin
                    r                = a;
                    shift_carry_next = cflag;
                end
                else if (sh_small)
                begin
                    r                = lsr_wide[32:1];
                    shift_carry_next = lsr_wide[0];
                end
                else
                begin
                    shift_carry_next = sh_32 ? a[31] : 1'b0;
                end
            end
            aasf_pkg::OP_ASR:
            begin
                if (sh_zero)
                begin
                    r                = a;
                    shift_carry_next = cflag;
                end
                else if (sh_small)
                begin
                    r                = asr_wide[32:1];
                    shift_carry_next = asr_wide[0];
                end
                else
                begin
                    r                = {32{a[31]}};
                    shift_carry_next = a[31];
                end
            end
            aasf_pkg::OP_ROR:
            begin
                if (sh_zero)
                begin
                    r                = a;
                    shift_carry_next = cflag;
                end
                else
                begin
                    r                = ror_wide;
                    shift_carry_next = ror_wide[31];
                end
            end
            aasf_pkg::OP_RRX:
            begin
                r                = {cflag, a[31:1]};
                shift_carry_next = a[0];
            end
            aasf_pkg::OP_LOGIC:
            begin
                r = a;
                if (item.set_flags)
                begin
                    flags_next[aasf_pkg::FL_N] = a[31];
                    flags_next[aasf_pkg::FL_Z] = (a == 32'd0);
                    flags_next[aasf_pkg::FL_C] = shift_carry;
                end
            end
            aasf_pkg::OP_MUL:
            begin
                r      = mac;
                cycles = 3'd1 + {2'd0, ones8} + {2'd0, ones16} + {2'd0, ones24};
                if (item.set_flags)
                begin
                    flags_next[aasf_pkg::FL_N] = mac[31];
                    flags_next[aasf_pkg::FL_Z] = (mac == 32'd0);
                end
            end
            aasf_pkg::OP_WRFLAGS:
            begin
                flags_next = a[31:28];
            end
            default:
            begin
                r = 32'd0;
            end
        endcase
    end

    always_comb
    begin
        res.result           = r;
        res.shift_carry_out  = shift_carry_next;
        res.flags_out        = flags_next;
        res.condition_passed = aasf_pkg::cond_holds(item.condition, flags_next);
        res.mul_cycles       = cycles;
    end

endmodule

[design/arm_alu_shifter_flags_core.sv]
// ALU, barrel shifter and NZCV flags. A request passes through the input register, then
// the result register, before its result is valid.
// Throughput: one request per cycle while res.ready is held high; the flags written by one
// request feed the next with no bubble.
// Reset (rst_n low, asynchronous): both stages empty, NZCV and shifter carry cleared.
// Depends on aasf_pkg, aasf_in_if, aasf_out_if and aasf_alu.
module arm_alu_shifter_flags_core (
    input  logic          clk,
    input  logic          rst_n,
    aasf_in_if.sink       cmd,
    aasf_out_if.source    res
);

    logic                s1_valid_reg;
    aasf_pkg::in_item_t  s1_item_reg;
    logic                out_valid_reg;
    aasf_pkg::out_item_t out_item_reg;
    logic [3:0]          flags_reg;
    logic                sc_reg;

    aasf_pkg::out_item_t out_item_next;
    logic [3:0]          flags_next;
    logic                sc_next;
    logic                advance;
    aasf_pkg::in_item_t  cmd_item;

    assign advance   = s1_valid_reg && (!out_valid_reg || res.ready);
    assign cmd.ready = !s1_valid_reg || advance;

    always_comb
    begin
        cmd_item.op           = cmd.op;
        cmd_item.operand_a    = cmd.operand_a;
        cmd_item.operand_b    = cmd.operand_b;
        cmd_item.operand_c    = cmd.operand_c;
        cmd_item.carry_in     = cmd.carry_in;
        cmd_item.shift_amount = cmd.shift_amount;
        cmd_item.set_flags    = cmd.set_flags;
        cmd_item.condition    = cmd.condition;
    end

    aasf_alu u_alu (
        .item             (s1_item_reg),
        .flags            (flags_reg),
        .shift_carry      (sc_reg),
        .res              (out_item_next),
        .flags_next       (flags_next),
        .shift_carry_next (sc_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= 4'd0;
            sc_reg        <= 1'b0;
        end
        else
        begin
            if (cmd.valid && cmd.ready)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                flags_reg     <= flags_next;
                sc_reg        <= sc_next;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            s1_item_reg <= cmd_item;
        end
        if (advance)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign res.valid            = out_valid_reg;
    assign res.result           = out_item_reg.result;
    assign res.shift_carry_out  = out_item_reg.shift_carry_out;
    assign res.flags_out        = out_item_reg.flags_out;
    assign res.condition_passed = out_item_reg.condition_passed;
    assign res.mul_cycles       = out_item_reg.mul_cycles;

`ifndef SYNTHESIS
    // the held result always reports the live flag state
    a_flags_track: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_item_reg.flags_out == flags_reg)
                          && (out_item_reg.shift_carry_out == sc_reg))
        else $error("result flags disagree with flag state");

    a_mul_cycles: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_item_reg.mul_cycles <= aasf_pkg::MAX_MUL_CYCLES))
        else $error("multiply cycle count out of range");

    // a request blocked by a full result stage must still be there next cycle
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |=> (s1_valid_reg && $stable(s1_item_reg)))
        else $error("input stage lost a request while stalled");

    a_flags_only_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(advance) |-> ($stable(flags_reg) && $stable(sc_reg)))
        else $error("flag state changed without a request completing");
`endif

endmodule
